@@ sv/tlas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlas_pkg
// Shared types and constants for the track length and average speed block.
// ----------------------------------------------------------------------------
package tlas_pkg;

  // Default geometry of the point fields
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 8;

  // Result widths are fixed
  localparam int LEN_W    = 48;
  localparam int STATUS_W = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_TIME = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take a point, update previous point
    logic mul_x;      // square dx
    logic mul_y;      // square dy, keep dx squared
    logic add_sq;     // form radicand, start root
    logic sqrt_step;  // one root bit
    logic acc_len;    // saturating add of the segment
    logic final_chk;  // classify the track, start divider
    logic div_step;   // one quotient bit
    logic load_out;   // move result to output, clear the track
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic point_seen;
    logic two_or_more;
    logic last;
    logic time_bad;
    logic cnt_zero;
  } sts_t;

endpackage

@@ sv/tlas_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlas_ctrl
// Sequencer for one point at a time: squaring, root iteration, accumulate,
// final divide, and the output handshake.
// ----------------------------------------------------------------------------
module tlas_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tlas_pkg::sts_t  sts_i,
  output tlas_pkg::cmd_t  cmd_o
);
  import tlas_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MULX  = 9'b000000010,
    S_MULY  = 9'b000000100,
    S_ADD   = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_FINAL = 9'b010000000,
    S_DIV   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   pend_q, pend_d;
  logic   load_now;

  // Output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Move a finished result into the output slot once it frees up
  assign load_now = pend_q && out_free;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !pend_q) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.point_seen ? S_MULX : S_NEXT;
        end
      end
      S_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_sq = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_len = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = sts_i.last ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        cmd_o.final_chk = 1'b1;
        state_d = (sts_i.two_or_more && !sts_i.time_bad) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.load_out = load_now;
  end

  // Hold the finished result until the output slot frees up
  always_comb begin
    pend_d = pend_q;
    if ((state_q == S_FINAL && !(sts_i.two_or_more && !sts_i.time_bad)) ||
        (state_q == S_DIV && sts_i.cnt_zero)) begin
      pend_d = 1'b1;
    end
    if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Ready only when idle and no result is waiting for the slot
  assign in_stall_o  = (state_q != S_IDLE) || pend_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/tlas_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlas_dpath
// Track state, shared squarer, bit-serial square root, saturating length
// accumulator, bit-serial divider and output registers.
// ----------------------------------------------------------------------------
module tlas_dpath #(
  parameter int COORD_WIDTH = tlas_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = tlas_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS   = tlas_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlas_pkg::cmd_t                cmd_i,
  output tlas_pkg::sts_t                sts_o,
  input  logic [COORD_WIDTH-1:0]        x_coord_i,
  input  logic [COORD_WIDTH-1:0]        y_coord_i,
  input  logic [TIME_WIDTH-1:0]         time_stamp_i,
  input  logic                          last_point_i,
  output logic [tlas_pkg::LEN_W-1:0]    track_length_o,
  output logic [tlas_pkg::LEN_W-1:0]    avg_speed_o,
  output logic [tlas_pkg::STATUS_W-1:0] status_o
);
  import tlas_pkg::*;

  localparam int RootW  = COORD_WIDTH + FRAC_BITS + 1;
  localparam int RadW   = 2 * RootW;
  localparam int ProdW  = 2 * COORD_WIDTH;
  localparam int SqW    = ProdW + 1;
  localparam int CntMax = (RootW > LEN_W) ? RootW : LEN_W;
  localparam int SumW   = CntMax + 1;
  localparam int CntW   = $clog2(CntMax);

  // Track state
  logic [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic [TIME_WIDTH-1:0]  start_q;
  logic                   point_seen_q, two_q;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [CntW-1:0]        cnt_q;

  // Working registers
  logic [TIME_WIDTH-1:0]  t_q;
  logic                   last_q;
  logic [COORD_WIDTH-1:0] dx_q, dy_q;
  logic [ProdW-1:0]       prod_q, sq_q;
  logic [RadW-1:0]        rad_q;
  logic [RootW+1:0]       rem_q;
  logic [RootW-1:0]       root_q;
  status_e                res_q;
  logic [TIME_WIDTH-1:0]  dvs_q;
  logic [LEN_W-1:0]       dq_q;
  logic [TIME_WIDTH-1:0]  drem_q;
  logic [LEN_W-1:0]       len_out_q, spd_out_q;
  status_e                status_out_q;

  // Absolute coordinate differences
  logic [COORD_WIDTH:0]   diff_x, diff_y, neg_x, neg_y;
  logic [COORD_WIDTH-1:0] dx_abs, dy_abs;

  assign diff_x = {x_coord_i[COORD_WIDTH-1], x_coord_i} -
                  {prev_x_q[COORD_WIDTH-1], prev_x_q};
  assign diff_y = {y_coord_i[COORD_WIDTH-1], y_coord_i} -
                  {prev_y_q[COORD_WIDTH-1], prev_y_q};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign dx_abs = diff_x[COORD_WIDTH] ? neg_x[COORD_WIDTH-1:0] : diff_x[COORD_WIDTH-1:0];
  assign dy_abs = diff_y[COORD_WIDTH] ? neg_y[COORD_WIDTH-1:0] : diff_y[COORD_WIDTH-1:0];

  // Shared squarer
  logic [COORD_WIDTH-1:0] mul_a;
  logic [ProdW-1:0]       prod;

  assign mul_a = cmd_i.mul_x ? dx_q : dy_q;
  assign prod  = mul_a * mul_a;

  // Sum of squares
  logic [SqW-1:0] sumsq;
  assign sumsq = SqW'(sq_q) + SqW'(prod_q);

  // One root bit: bring down a bit pair, try 4*root+1
  logic [RootW+1:0] rem_sh, trial, rem_sub;
  logic             root_ge;

  assign rem_sh  = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign root_ge = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // Saturating length accumulate
  logic [SumW-1:0] len_sum;
  assign len_sum = SumW'(root_q) + SumW'(len_q);
  assign len_d   = (len_sum[SumW-1:LEN_W] != '0) ? '1 : len_sum[LEN_W-1:0];

  // One quotient bit
  logic [TIME_WIDTH:0] drem_sh, drem_sub;
  logic                div_ge;

  assign drem_sh  = {drem_q, dq_q[LEN_W-1]};
  assign drem_sub = drem_sh - {1'b0, dvs_q};
  assign div_ge   = !drem_sub[TIME_WIDTH];

  // Elapsed time and its check
  logic                  time_bad;
  logic [TIME_WIDTH-1:0] elapsed;

  assign time_bad = t_q <= start_q;
  assign elapsed  = t_q - start_q;

  // Track state and iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      start_q      <= '0;
      point_seen_q <= 1'b0;
      two_q        <= 1'b0;
      len_q        <= '0;
      cnt_q        <= '0;
    end else begin
      if (cmd_i.accept) begin
        prev_x_q <= x_coord_i;
        prev_y_q <= y_coord_i;
        if (!point_seen_q) begin
          point_seen_q <= 1'b1;
          start_q      <= time_stamp_i;
          len_q        <= '0;
        end
      end else if (cmd_i.add_sq) begin
        cnt_q <= CntW'(RootW - 1);
      end else if (cmd_i.sqrt_step || cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.acc_len) begin
        len_q <= len_d;
        two_q <= 1'b1;
      end else if (cmd_i.final_chk) begin
        cnt_q <= CntW'(LEN_W - 1);
      end else if (cmd_i.load_out) begin
        prev_x_q     <= '0;
        prev_y_q     <= '0;
        start_q      <= '0;
        point_seen_q <= 1'b0;
        two_q        <= 1'b0;
        len_q        <= '0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q    <= time_stamp_i;
      last_q <= last_point_i;
      dx_q   <= dx_abs;
      dy_q   <= dy_abs;
    end
    if (cmd_i.mul_x) begin
      prod_q <= prod;
    end
    if (cmd_i.mul_y) begin
      sq_q   <= prod_q;
      prod_q <= prod;
    end
    if (cmd_i.add_sq) begin
      rad_q  <= RadW'(sumsq) << (2 * FRAC_BITS);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_ge ? rem_sub : rem_sh;
      root_q <= {root_q[RootW-2:0], root_ge};
    end
    if (cmd_i.final_chk) begin
      if (!two_q) begin
        res_q <= ST_SHORT;
      end else if (time_bad) begin
        res_q <= ST_BAD_TIME;
      end else begin
        res_q <= ST_OK;
      end
      dvs_q  <= elapsed;
      dq_q   <= len_q;
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= div_ge ? drem_sub[TIME_WIDTH-1:0] : drem_sh[TIME_WIDTH-1:0];
      dq_q   <= {dq_q[LEN_W-2:0], div_ge};
    end
    if (cmd_i.load_out) begin
      len_out_q    <= len_q;
      spd_out_q    <= (res_q == ST_OK) ? dq_q : '0;
      status_out_q <= res_q;
    end
  end

  assign sts_o.point_seen  = point_seen_q;
  assign sts_o.two_or_more = two_q;
  assign sts_o.last        = last_q;
  assign sts_o.time_bad    = time_bad;
  assign sts_o.cnt_zero    = (cnt_q == '0);

  assign track_length_o = len_out_q;
  assign avg_speed_o    = spd_out_q;
  assign status_o       = status_out_q;

endmodule

@@ sv/track_length_and_average_speed.sv @@
`timescale 1ns / 1ps
// A first point only records its position and time; a later point is squared, its
//   root taken by the one-bit-per-cycle square root, and the segment accumulated.
// A last point then runs the bit-serial divider before its item shows;
//   a single-point or mistimed track skips the divider.
// The input stalls while a point is in work or a result is pending; the output
//   register lets a result wait. Reset: asynchronous, active low; clears track and valid.
// ----------------------------------------------------------------------------
// track_length_and_average_speed
// Path length and average speed of a track of timestamped 2-D points.
// ----------------------------------------------------------------------------
module track_length_and_average_speed #(
  parameter int COORD_WIDTH = tlas_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = tlas_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS   = tlas_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COORD_WIDTH-1:0]        x_coord_i,
  input  logic [COORD_WIDTH-1:0]        y_coord_i,
  input  logic [TIME_WIDTH-1:0]         time_stamp_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tlas_pkg::LEN_W-1:0]    track_length_o,
  output logic [tlas_pkg::LEN_W-1:0]    avg_speed_o,
  output logic [tlas_pkg::STATUS_W-1:0] status_o
);
  import tlas_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  tlas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and track state
  tlas_dpath #(
    .COORD_WIDTH (COORD_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .time_stamp_i   (time_stamp_i),
    .last_point_i   (last_point_i),
    .track_length_o (track_length_o),
    .avg_speed_o    (avg_speed_o),
    .status_o       (status_o)
  );

endmodule

@@ sv/tlas_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlas_checker
// Port-level checks on both channels, bound to the top level.
// ----------------------------------------------------------------------------
module tlas_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tlas_pkg::LEN_W-1:0]    track_length_o,
  input logic [tlas_pkg::LEN_W-1:0]    avg_speed_o,
  input logic [tlas_pkg::STATUS_W-1:0] status_o
);
  import tlas_pkg::*;

  // An accepted point keeps the input busy for the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accepted item");

  // A stalled item stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled item keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(track_length_o) && $stable(avg_speed_o)
      && $stable(status_o))
    else $error("result payload changed while stalled");

  // A track of one point reports nothing but its status
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SHORT) |-> (track_length_o == '0) && (avg_speed_o == '0))
    else $error("single-point track with nonzero length or speed");

  // Speed is length over at least one tick, zero unless status is ok
  a_speed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (avg_speed_o <= track_length_o) &&
      ((status_o == ST_OK) || (avg_speed_o == '0)))
    else $error("average speed out of range for the reported length");

endmodule

bind track_length_and_average_speed tlas_checker u_tlas_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tracks of timestamped points into track_length_and_average_speed and
// checks every track result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

  import tlas_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 10;
  localparam int TAIL_CYCLES = 100;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // One expected track result
  typedef struct {
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] speed;
    status_e          status;
  } track_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] x_coord_i = '0;
  logic signed [15:0] y_coord_i = '0;
  logic [31:0]        time_stamp_i = '0;
  logic               last_point_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LEN_W-1:0]   track_length_o;
  logic [LEN_W-1:0]   avg_speed_o;
  logic [STATUS_W-1:0] status_o;

  // Predictor state of the track in progress
  logic signed [15:0] trk_prev_x;
  logic signed [15:0] trk_prev_y;
  logic [31:0]        trk_start_time;
  logic               trk_point_seen;
  logic               trk_two_or_more;
  logic [LEN_W-1:0]   trk_length_sum;

  track_result_t track_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt = 0;
  int points_sent = 0;
  int tracks_checked = 0;

  track_length_and_average_speed dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .time_stamp_i   (time_stamp_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .track_length_o (track_length_o),
    .avg_speed_o    (avg_speed_o),
    .status_o       (status_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Integer square root, one result bit per pass
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic void clear_track();
    trk_prev_x = '0;
    trk_prev_y = '0;
    trk_start_time = '0;
    trk_point_seen = 1'b0;
    trk_two_or_more = 1'b0;
    trk_length_sum = '0;
  endfunction

  // Advance the track by one point; queue a result on the last point
  function automatic void predict_point(input logic signed [15:0] x, input logic signed [15:0] y,
                                        input logic [31:0] t, input logic last);
    longint dx;
    longint dy;
    longint unsigned radicand;
    longint unsigned seg;
    track_result_t res;
    if (!trk_point_seen) begin
      trk_point_seen = 1'b1;
      trk_start_time = t;
      trk_length_sum = '0;
    end else begin
      dx = longint'(x) - longint'(trk_prev_x);
      dy = longint'(y) - longint'(trk_prev_y);
      radicand = longint'(dx * dx + dy * dy) << (2 * FRAC_BITS_DEF);
      seg = isqrt(radicand);
      if (seg > longint'(LEN_MAX - trk_length_sum)) trk_length_sum = LEN_MAX;
      else trk_length_sum = trk_length_sum + seg[LEN_W-1:0];
      trk_two_or_more = 1'b1;
    end
    trk_prev_x = x;
    trk_prev_y = y;
    if (last) begin
      if (!trk_two_or_more) begin
        res.length = '0;
        res.speed = '0;
        res.status = ST_SHORT;
      end else if (t <= trk_start_time) begin
        res.length = trk_length_sum;
        res.speed = '0;
        res.status = ST_BAD_TIME;
      end else begin
        res.length = trk_length_sum;
        res.speed = trk_length_sum / (t - trk_start_time);
        res.status = ST_OK;
      end
      track_q.push_back(res);
      clear_track();
    end
  endfunction

  // Offer one point, hold it until taken, then predict its effect
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] t, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    time_stamp_i <= t;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_point(x, y, t, last);
    points_sent++;
  endtask

  // Hold off the sender until every pending track result is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (track_q.size() != 0) @(posedge clk_i);
  endtask

  // Check each accepted result against the oldest pending track
  always @(posedge clk_i) begin : check_results
    track_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (track_q.size() == 0) begin
        $error("result with no track pending: length %0d speed %0d status %0d",
               track_length_o, avg_speed_o, status_o);
        err_cnt++;
      end else begin
        want = track_q.pop_front();
        tracks_checked++;
        if (track_length_o !== want.length) begin
          $error("track_length: expected %0d, actual %0d", want.length, track_length_o);
          err_cnt++;
        end
        if (avg_speed_o !== want.speed) begin
          $error("avg_speed: expected %0d, actual %0d", want.speed, avg_speed_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Single-point tracks, both right after reset and after a full track
  task automatic test_single_point();
    send_point(16'sd5, -16'sd7, 32'd1000, 1'b1);
    send_point(16'sd0, 16'sd0, 32'd0, 1'b0);
    send_point(16'sd3, 16'sd4, 32'd10, 1'b1);
    send_point(16'sd32767, -16'sd32768, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Last timestamp equal to or below the first
  task automatic test_time_not_positive();
    send_point(16'sd0, 16'sd0, 32'd500, 1'b0);
    send_point(16'sd300, 16'sd400, 32'd500, 1'b1);
    send_point(-16'sd10, 16'sd10, 32'hFFFF_FFFF, 1'b0);
    send_point(16'sd10, -16'sd10, 32'h0000_0000, 1'b1);
  endtask

  // Corner-to-corner segments, up to the longest possible, with elapsed time of one tick
  task automatic test_extreme_coords();
    send_point(-16'sd32768, -16'sd32768, 32'd0, 1'b0);
    send_point(16'sd32767, 16'sd32767, 32'd0, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 32'd0, 1'b0);
    send_point(16'sd32767, -16'sd32768, 32'd1, 1'b1);
    send_point(16'sd32767, 16'sd32767, 32'hFFFF_FFFE, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Timestamps running backwards inside a track, and a zero-length track
  task automatic test_backward_and_still();
    send_point(16'sd1, 16'sd1, 32'd100, 1'b0);
    send_point(16'sd2, 16'sd2, 32'd50, 1'b0);
    send_point(16'sd4, -16'sd3, 32'd10, 1'b0);
    send_point(-16'sd1, 16'sd9, 32'd200, 1'b1);
    send_point(16'sd77, 16'sd77, 32'd7, 1'b0);
    send_point(16'sd77, 16'sd77, 32'd8, 1'b0);
    send_point(16'sd77, 16'sd77, 32'd9, 1'b1);
  endtask

  // Random tracks: mostly ordered timestamps, some scrambled ones
  task automatic test_random_tracks(input int n_points);
    int sent;
    int trk_len;
    int pick;
    logic scrambled;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [31:0] cur_t;
    sent = 0;
    while (sent < n_points) begin
      pick = $urandom_range(99);
      if (pick < 10) trk_len = 1;
      else if (pick < 90) trk_len = $urandom_range(2, 8);
      else trk_len = $urandom_range(9, 20);
      scrambled = ($urandom_range(99) < 25);
      cur_x = 16'($urandom);
      cur_y = 16'($urandom);
      cur_t = $urandom;
      for (int i = 0; i < trk_len; i++) begin
        send_point(cur_x, cur_y, cur_t, i == trk_len - 1);
        sent++;
        // Step to the next point: a far jump or a short move
        if ($urandom_range(1)) cur_x = 16'($urandom);
        else cur_x = 16'(int'(cur_x) + int'($urandom_range(0, 512)) - 256);
        if ($urandom_range(1)) cur_y = 16'($urandom);
        else cur_y = 16'(int'(cur_y) + int'($urandom_range(0, 512)) - 256);
        if (scrambled) cur_t = $urandom;
        else if ($urandom_range(3) == 0) cur_t = cur_t + $urandom_range(0, 1);
        else cur_t = cur_t + $urandom_range(0, 5000);
      end
    end
  endtask

  initial begin
    clear_track();
    send_idle_pct = 9;
    recv_idle_pct = 48;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_point();
    test_time_not_positive();
    test_extreme_coords();
    test_backward_and_still();
    drain_results();

    test_random_tracks(375);
    drain_results();
    send_idle_pct = 48;
    recv_idle_pct = 9;
    test_random_tracks(375);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tracks(375);

    // Let the last track finish and catch any stray result
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (track_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d points and checked %0d track results,", points_sent, tracks_checked);
    $display("covering short, mistimed, extreme and random tracks under three stall mixes.");
    if (err_cnt == 0 && track_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(10_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
